>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every edge outside reset.
`define VWMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition at one edge leads to another at the next edge.
`define VWMA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/vwma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Sequencer state codes and address width helper shared by the design files.
// ----------------------------------------------------------------------------
package vwma_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Address bits for a memory of the given depth, at least one
    function automatic int addr_bits(input int depth);
        int bits;
        bits = $clog2(depth);
        return (bits < 1) ? 1 : bits;
    endfunction

endpackage

>>> src/vwma_if.sv
// ----------------------------------------------------------------------------
// Moving average stream interfaces
// Valid/ready channels for the bar words in and the average words out.
// ----------------------------------------------------------------------------
interface vwma_in_if #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int LENGTH_WIDTH = 11
);
    logic                           valid;
    logic                           ready;
    logic                           first_of_series;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_valid;
    logic        [LENGTH_WIDTH-1:0] window_length;
    logic                           length_too_big;

    modport source (
        output valid, first_of_series, sample, sample_valid, window_length,
               length_too_big,
        input  ready
    );
    modport sink (
        input  valid, first_of_series, sample, sample_valid, window_length,
               length_too_big,
        output ready
    );
endinterface

interface vwma_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] average;
    logic                           average_valid;

    modport source (
        output valid, average, average_valid,
        input  ready
    );
    modport sink (
        input  valid, average, average_valid,
        output ready
    );
endinterface

>>> src/vwma_ring_ram.sv
// ----------------------------------------------------------------------------
// Prefix ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vwma_ring_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 42
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [vwma_pkg::addr_bits(DEPTH)-1:0]      i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [vwma_pkg::addr_bits(DEPTH)-1:0]      i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write the stored prefix
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; the data follows in the cycle after i_rd_en
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> src/vwma_divider.sv
// ----------------------------------------------------------------------------
// Window sum divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vwma_divider #(
    parameter int DIVIDEND_WIDTH = 42,
    parameter int DIVISOR_WIDTH  = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIVIDEND_WIDTH-1:0] i_dividend,
    input  logic [DIVISOR_WIDTH-1:0]  i_divisor,
    output logic                      o_done,
    output logic [DIVIDEND_WIDTH-1:0] o_quotient
);
    localparam int DW   = DIVIDEND_WIDTH;
    localparam int VW   = DIVISOR_WIDTH;
    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [VW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_quo, n_quo;
    logic [VW-1:0]   r_div, n_div;
    logic [VW:0]     w_rem_sh;
    logic            w_ge;
    logic [VW:0]     w_rem_sub;

    // Shift in the next dividend bit and try a subtract
    assign w_rem_sh  = {r_rem, r_quo[DW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(DW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_rem_sub[VW-1:0] : w_rem_sh[VW-1:0];
            n_quo = {r_quo[DW-2:0], w_ge};
            n_cnt = r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control under reset, datapath free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `VWMA_ASSERT(a_div_start_idle, i_start |-> !r_busy, "divider started while busy")
    `VWMA_ASSERT(a_div_done_alone, r_done |-> !r_busy, "divider done while still busy")
    `VWMA_ASSERT_NEXT(a_div_runs, i_start, r_busy, "divider did not start")
endmodule

>>> src/variable_window_moving_average_unit.sv
// ----------------------------------------------------------------------------
// Variable window moving average unit
// Mean of the last N bars of a Q16.16 series, taken as the running prefix
// minus a prefix stored N bars ago in a ring memory, then divided by N.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Word
//  i_in     in   i_in.valid/ready     first_of_series, sample, sample_valid,
//                                     window_length, length_too_big
//  o_out    out  o_out.valid/ready    average, average_valid
//
//  One bar at a time. A bar with an average waits on the one-bit-per-cycle
//  divider; a bar without one skips it. The ring is read in the cycle that
//  accepts a bar and the prefix written back in the cycle after. i_rst_n is
//  synchronous, active low, and clears the series state; the ring needs no
//  clearing pass. The output register holds a finished word while
//  o_out.ready is low, and the next bar is still accepted and worked until
//  its own result is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module variable_window_moving_average_unit #(
    parameter int MAX_PERIOD   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vwma_in_if.sink      i_in,
    vwma_out_if.source   o_out
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = SAMPLE_WIDTH + $clog2(MAX_PERIOD);
    localparam int AW = vwma_pkg::addr_bits(MAX_PERIOD);
    localparam int LW = $clog2(MAX_PERIOD + 1);
    localparam int CW = $clog2(MAX_PERIOD + 2);
    localparam int IW = LW + 1;

    vwma_pkg::t_state r_state, n_state;

    // Series state
    logic          r_seen, n_seen;
    logic [PW-1:0] r_prefix, n_prefix;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_bars, n_bars;

    // Per-bar work registers
    logic          r_have, n_have;
    logic          r_use_base, n_use_base;
    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_wptr, n_wptr;
    logic          r_neg, n_neg;
    logic [SW-1:0] r_res_avg, n_res_avg;
    logic          r_res_valid, n_res_valid;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [SW-1:0] r_out_avg, n_out_avg;
    logic          r_out_avg_valid, n_out_avg_valid;

    logic                 w_accept;
    logic                 w_seen0;
    logic [PW-1:0]        w_prefix0, w_prefix1;
    logic [AW-1:0]        w_ptr0, w_ptr_next;
    logic [CW-1:0]        w_bars0, w_bars1;
    logic signed [PW-1:0] w_sample_ext;
    logic [CW-1:0]        w_len_c;
    logic                 w_have, w_use_base;
    logic [IW-1:0]        w_idx_wide;
    logic [AW-1:0]        w_idx;
    logic                 w_rd_en, w_wr_en;
    logic [PW-1:0]        w_rd_data;
    logic [PW-1:0]        w_base, w_diff, w_mag;
    logic                 w_div_start, w_div_done;
    logic [PW-1:0]        w_quo, w_quo_neg;
    logic                 w_load;

    // Clear the series ahead of a first bar
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_seen0      = i_in.first_of_series ? 1'b0 : r_seen;
    assign w_prefix0    = i_in.first_of_series ? '0 : r_prefix;
    assign w_ptr0       = i_in.first_of_series ? '0 : r_ptr;
    assign w_bars0      = i_in.first_of_series ? '0 : r_bars;

    // Advance prefix and saturating bar count
    assign w_sample_ext = PW'(i_in.sample);
    assign w_prefix1    = i_in.sample_valid ? (w_prefix0 + w_sample_ext) : w_prefix0;
    assign w_bars1      = (w_bars0 <= CW'(MAX_PERIOD)) ? (w_bars0 + CW'(1)) : w_bars0;
    assign w_ptr_next   = (w_ptr0 == AW'(MAX_PERIOD - 1)) ? '0 : (w_ptr0 + AW'(1));

    // Decide whether a window mean exists and whether it needs a base
    assign w_len_c    = CW'(i_in.window_length);
    assign w_have     = !i_in.length_too_big && (i_in.window_length != '0) &&
                        (i_in.window_length <= LW'(MAX_PERIOD)) && (w_len_c <= w_bars1);
    assign w_use_base = w_have && (w_len_c < w_bars1);

    // Ring slot written window_length bars ago
    assign w_idx_wide = (IW'(w_ptr0) >= IW'(i_in.window_length))
                      ? (IW'(w_ptr0) - IW'(i_in.window_length))
                      : (IW'(w_ptr0) + IW'(MAX_PERIOD) - IW'(i_in.window_length));
    assign w_idx      = w_idx_wide[AW-1:0];

    // Window sum and its magnitude
    assign w_base    = r_use_base ? w_rd_data : '0;
    assign w_diff    = r_prefix - w_base;
    assign w_mag     = w_diff[PW-1] ? (~w_diff + PW'(1)) : w_diff;
    assign w_quo_neg = ~w_quo + PW'(1);

    assign w_load = (r_state == vwma_pkg::S_DONE) && (!r_out_valid || o_out.ready);

    // Sequence one bar: accept, read base and divide as needed, hand over
    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_prefix    = r_prefix;
        n_ptr       = r_ptr;
        n_bars      = r_bars;
        n_have      = r_have;
        n_use_base  = r_use_base;
        n_len       = r_len;
        n_wptr      = r_wptr;
        n_neg       = r_neg;
        n_res_avg   = r_res_avg;
        n_res_valid = r_res_valid;
        w_rd_en     = 1'b0;
        w_wr_en     = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            vwma_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!w_seen0 && !i_in.sample_valid) begin
                        // Not counted: apply the clear and drop the bar
                        n_seen      = 1'b0;
                        n_prefix    = w_prefix0;
                        n_ptr       = w_ptr0;
                        n_bars      = w_bars0;
                        n_res_avg   = '0;
                        n_res_valid = 1'b0;
                        n_state     = vwma_pkg::S_DONE;
                    end else begin
                        n_seen     = 1'b1;
                        n_prefix   = w_prefix1;
                        n_bars     = w_bars1;
                        n_ptr      = w_ptr_next;
                        n_wptr     = w_ptr0;
                        n_have     = w_have;
                        n_use_base = w_use_base;
                        n_len      = i_in.window_length;
                        w_rd_en    = 1'b1;
                        n_state    = vwma_pkg::S_READ;
                    end
                end
            end
            vwma_pkg::S_READ: begin
                // Base is in; store this bar's prefix behind it
                w_wr_en = 1'b1;
                if (r_have) begin
                    w_div_start = 1'b1;
                    n_neg       = w_diff[PW-1];
                    n_state     = vwma_pkg::S_DIV;
                end else begin
                    n_res_avg   = '0;
                    n_res_valid = 1'b0;
                    n_state     = vwma_pkg::S_DONE;
                end
            end
            vwma_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_res_avg   = r_neg ? w_quo_neg[SW-1:0] : w_quo[SW-1:0];
                    n_res_valid = 1'b1;
                    n_state     = vwma_pkg::S_DONE;
                end
            end
            vwma_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = vwma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vwma_pkg::S_IDLE;
            end
        endcase
    end

    // Load the output word, drop it once taken
    always_comb begin
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_avg       = r_out_avg;
        n_out_avg_valid = r_out_avg_valid;
        if (w_load) begin
            n_out_valid     = 1'b1;
            n_out_avg       = r_res_avg;
            n_out_avg_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vwma_pkg::S_IDLE;
            r_seen      <= 1'b0;
            r_prefix    <= '0;
            r_ptr       <= '0;
            r_bars      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_prefix    <= n_prefix;
            r_ptr       <= n_ptr;
            r_bars      <= n_bars;
            r_out_valid <= n_out_valid;
        end
        r_have          <= n_have;
        r_use_base      <= n_use_base;
        r_len           <= n_len;
        r_wptr          <= n_wptr;
        r_neg           <= n_neg;
        r_res_avg       <= n_res_avg;
        r_res_valid     <= n_res_valid;
        r_out_avg       <= n_out_avg;
        r_out_avg_valid <= n_out_avg_valid;
    end

    vwma_ring_ram #(
        .DEPTH (MAX_PERIOD),
        .WIDTH (PW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wptr),
        .i_wr_data (r_prefix),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_idx),
        .o_rd_data (w_rd_data)
    );

    vwma_divider #(
        .DIVIDEND_WIDTH (PW),
        .DIVISOR_WIDTH  (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_len),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign i_in.ready          = (r_state == vwma_pkg::S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.average       = r_out_avg;
    assign o_out.average_valid = r_out_avg_valid;

    `VWMA_ASSERT(a_empty_series, !r_seen |-> (r_prefix == '0) && (r_bars == '0), "history kept before first valid sample")
    `VWMA_ASSERT(a_bars_sat, r_bars <= CW'(MAX_PERIOD + 1), "bar count past saturation")
    `VWMA_ASSERT(a_ptr_range, r_ptr <= AW'(MAX_PERIOD - 1), "ring pointer out of range")
    `VWMA_ASSERT(a_missing_zero, r_out_valid && !r_out_avg_valid |-> r_out_avg == '0, "missing average not zero")
    `VWMA_ASSERT_NEXT(a_div_to_done, (r_state == vwma_pkg::S_DIV) && w_div_done, r_state == vwma_pkg::S_DONE, "quotient not taken")
endmodule

>>> tb/sv/variable_window_moving_average_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Variable window moving average unit testbench
// Streams bars through the unit, follows the running prefix and its ring in a
// small class, and checks every average word in order against the window
// mean that the class works out. Both channels idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module variable_window_moving_average_unit_tb;

    localparam int MAX_PERIOD   = 1024;
    localparam int SAMPLE_WIDTH = 32;
    localparam int LENGTH_WIDTH = 11;
    localparam int RING_BITS    = $clog2(MAX_PERIOD);
    localparam int LENGTH_TOP   = (1 << LENGTH_WIDTH) - 1;
    localparam int RANDOM_BARS  = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_LIMIT = 30;

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                    first_of_series;
        logic [SAMPLE_WIDTH-1:0] sample;
        logic                    sample_valid;
        logic [LENGTH_WIDTH-1:0] window_length;
        logic                    length_too_big;
    } t_bar;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] average;
        logic                    average_valid;
    } t_mean;

    // Window means of the bar series, one awaited word per accepted bar
    class t_window_mean_model;
        bit [63:0]          prefix_ring [MAX_PERIOD];
        bit [63:0]          running_prefix;
        bit [RING_BITS-1:0] ring_ptr;
        int                 bars_counted;
        bit                 seen_valid;
        t_mean              awaited_means [$];
        int                 fails;

        function new();
            clear_series();
            fails = 0;
        endfunction

        function void clear_series();
            running_prefix = '0;
            ring_ptr       = '0;
            bars_counted   = 0;
            seen_valid     = 1'b0;
        endfunction

        // Advance the series by one bar and queue the word it should produce
        function void take_bar(t_bar bar);
            bit [63:0] base;
            bit [63:0] diff;
            bit [63:0] mag;
            bit [63:0] quot;
            int        len;
            t_mean     mean;
            len  = int'(bar.window_length);
            base = '0;
            mean = '0;
            if (bar.first_of_series)
                clear_series();
            // Bars ahead of the first present sample are not counted
            if (seen_valid || bar.sample_valid) begin
                seen_valid = 1'b1;
                if (bar.sample_valid)
                    running_prefix += {{(64-SAMPLE_WIDTH){bar.sample[SAMPLE_WIDTH-1]}},
                                       bar.sample};
                if (bars_counted <= MAX_PERIOD)
                    bars_counted++;
                if (!bar.length_too_big && len >= 1 && len <= MAX_PERIOD &&
                    len <= bars_counted) begin
                    // A window spanning the whole series starts from zero
                    if (len < bars_counted)
                        base = prefix_ring[RING_BITS'((int'(ring_ptr) - len + MAX_PERIOD)
                                                      % MAX_PERIOD)];
                    diff = running_prefix - base;
                    mag  = diff[63] ? -diff : diff;
                    quot = mag / 64'(len);
                    if (diff[63])
                        quot = -quot;
                    mean.average       = quot[SAMPLE_WIDTH-1:0];
                    mean.average_valid = 1'b1;
                end
                // Store the prefix only after the base has been read
                prefix_ring[ring_ptr] = running_prefix;
                ring_ptr = RING_BITS'((int'(ring_ptr) + 1) % MAX_PERIOD);
            end
            awaited_means = {awaited_means, mean};
        endfunction

        // Compare one average word with the oldest awaited one
        function void check_mean(t_mean got);
            t_mean want;
            if (awaited_means.size() == 0) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $error("average word with none awaited: average %h, average_valid %0d",
                           got.average, got.average_valid);
                return;
            end
            want = awaited_means.pop_front();
            if (got.average_valid !== want.average_valid) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $error("average_valid: expected %0d, got %0d",
                           want.average_valid, got.average_valid);
            end
            if (got.average !== want.average) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $error("average: expected %h, got %h", want.average, got.average);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic hold_off;
    bit   calm;
    int   cycles;
    int   bars_accepted;

    t_window_mean_model model = new();

    vwma_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .LENGTH_WIDTH(LENGTH_WIDTH)) bar_if ();
    vwma_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) avg_if ();

    variable_window_moving_average_unit #(
        .MAX_PERIOD   (MAX_PERIOD),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bar_if),
        .o_out   (avg_if)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Note accepted bars and check accepted average words
    always @(posedge i_clk) begin
        if (i_rst_n && bar_if.valid && bar_if.ready) begin
            model.take_bar(t_bar'{bar_if.first_of_series, bar_if.sample, bar_if.sample_valid,
                                  bar_if.window_length, bar_if.length_too_big});
            bars_accepted++;
        end
        if (i_rst_n && avg_if.valid && avg_if.ready)
            model.check_mean(t_mean'{avg_if.average, avg_if.average_valid});
    end

    // Offer one bar after a random gap and hold it until it is taken
    task automatic send_bar(input t_bar bar);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            bar_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bar_if.valid           <= 1'b1;
        bar_if.first_of_series <= bar.first_of_series;
        bar_if.sample          <= bar.sample;
        bar_if.sample_valid    <= bar.sample_valid;
        bar_if.window_length   <= bar.window_length;
        bar_if.length_too_big  <= bar.length_too_big;
        do @(posedge i_clk); while (!bar_if.ready);
    endtask

    // Receiver: park ready between words at random, stall on a new word
    initial begin : mean_sink
        int stall;
        bit parked;
        bit presented;
        stall     = 0;
        parked    = 1'b0;
        presented = 1'b0;
        avg_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (avg_if.valid && avg_if.ready) begin
                parked    = !calm && ($urandom_range(0, 1) == 1);
                presented = 1'b0;
            end else if (avg_if.valid && !presented) begin
                presented = 1'b1;
                parked    = 1'b0;
                stall     = calm ? 0 : $urandom_range(0, 5);
            end else if (stall > 0) begin
                stall--;
            end
            avg_if.ready <= i_rst_n && !hold_off && !parked && stall == 0;
        end
    end

    // Hold the output off long enough for the unit to stall its input
    initial begin : long_hold
        hold_off <= 1'b0;
        wait (bars_accepted >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        t_bar bar;
        int   n;
        int   room;
        int   pick;
        int   bias;
        int   len_pick;
        int   gen_count;
        bit   gen_seen;
        calm      = 1'b0;
        bias      = 0;
        gen_count = 0;
        gen_seen  = 1'b0;
        i_rst_n                <= 1'b0;
        bar_if.valid           <= 1'b0;
        bar_if.first_of_series <= 1'b0;
        bar_if.sample          <= '0;
        bar_if.sample_valid    <= 1'b0;
        bar_if.window_length   <= '0;
        bar_if.length_too_big  <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Missing samples ahead of the first present one are not counted
        send_bar(t_bar'{1'b1, 32'h1234_5678, 1'b0, 11'd1, 1'b0});
        send_bar(t_bar'{1'b0, 32'hFFFF_FFFF, 1'b0, 11'd0, 1'b1});
        // Extremes, truncation toward zero, full-series window
        send_bar(t_bar'{1'b0, SAMPLE_MAX, 1'b1, 11'd1, 1'b0});
        send_bar(t_bar'{1'b0, SAMPLE_MIN, 1'b1, 11'd2, 1'b0});
        send_bar(t_bar'{1'b0, SAMPLE_MIN, 1'b1, 11'd3, 1'b0});
        // A missing sample still counts in the divisor
        send_bar(t_bar'{1'b0, 32'h5555_5555, 1'b0, 11'd4, 1'b0});
        // Lengths that give no average: too long, zero, flagged, above the ring
        send_bar(t_bar'{1'b0, 32'hAAAA_AAAA, 1'b1, 11'd6, 1'b0});
        send_bar(t_bar'{1'b0, 32'h0001_0000, 1'b1, 11'd0, 1'b0});
        send_bar(t_bar'{1'b0, 32'hFFFF_0000, 1'b1, 11'd3, 1'b1});
        send_bar(t_bar'{1'b0, SAMPLE_MAX, 1'b1, 11'(MAX_PERIOD), 1'b0});
        send_bar(t_bar'{1'b0, SAMPLE_MIN, 1'b1, 11'(MAX_PERIOD + 1), 1'b0});
        send_bar(t_bar'{1'b0, 32'h0000_0000, 1'b1, 11'(LENGTH_TOP), 1'b0});
        // Negative means round toward zero
        send_bar(t_bar'{1'b0, 32'hFFFF_FFFF, 1'b1, 11'd1, 1'b0});
        send_bar(t_bar'{1'b0, 32'hFFFF_FFFE, 1'b1, 11'd2, 1'b0});
        send_bar(t_bar'{1'b0, 32'h0000_0003, 1'b1, 11'd13, 1'b0});
        // New series mid-stream, then one that opens on a missing sample
        send_bar(t_bar'{1'b1, 32'h0000_0005, 1'b1, 11'd1, 1'b0});
        send_bar(t_bar'{1'b1, 32'h7000_0000, 1'b0, 11'd1, 1'b0});
        send_bar(t_bar'{1'b0, 32'h0000_0007, 1'b1, 11'd1, 1'b0});
        send_bar(t_bar'{1'b0, 32'h0000_0000, 1'b0, 11'd2, 1'b0});
        send_bar(t_bar'{1'b1, SAMPLE_MAX, 1'b1, 11'd1, 1'b1});
        send_bar(t_bar'{1'b0, SAMPLE_MAX, 1'b1, 11'd2, 1'b0});
        send_bar(t_bar'{1'b0, 32'h0000_0000, 1'b1, 11'(MAX_PERIOD), 1'b0});

        // One long series that wraps the ring, then many short ones
        for (n = 0; n < RANDOM_BARS; n++) begin
            if (n % 64 == 0)
                bias = $urandom_range(0, 5);
            calm = ((n / 128) % 5) == 4;
            bar = '0;
            bar.first_of_series = (n == 0) || (n >= 1300 && $urandom_range(0, 39) == 0);
            bar.sample_valid    = $urandom_range(0, 9) != 0;
            case (bias)
                3: bar.sample = 32'(int'($urandom_range(0, 511)) - 256);
                4: bar.sample = ($urandom_range(0, 7) != 0) ? SAMPLE_MAX : 32'($urandom());
                5: bar.sample = ($urandom_range(0, 7) != 0) ? SAMPLE_MIN : 32'($urandom());
                default: bar.sample = 32'($urandom());
            endcase
            // Track the bars counted so lengths land around the series size
            if (bar.first_of_series) begin
                gen_seen  = 1'b0;
                gen_count = 0;
            end
            if (gen_seen || bar.sample_valid) begin
                gen_seen = 1'b1;
                if (gen_count <= MAX_PERIOD)
                    gen_count++;
            end
            room = (gen_count < MAX_PERIOD) ? gen_count : MAX_PERIOD;
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len_pick = (room > 0) ? int'($urandom_range(1, room))
                                      : int'($urandom_range(1, 16));
            end else if (pick < 70) begin
                len_pick = (room > 0) ? room : 1;
            end else if (pick < 78) begin
                len_pick = int'($urandom_range(1, 8));
            end else if (pick < 85) begin
                len_pick = (room < MAX_PERIOD) ? int'($urandom_range(room + 1, MAX_PERIOD))
                                               : int'($urandom_range(MAX_PERIOD + 1,
                                                                     LENGTH_TOP));
            end else if (pick < 90) begin
                len_pick = 0;
            end else if (pick < 95) begin
                bar.length_too_big = 1'b1;
                len_pick = int'($urandom_range(0, LENGTH_TOP));
            end else begin
                len_pick = int'($urandom_range(MAX_PERIOD + 1, LENGTH_TOP));
            end
            bar.window_length = LENGTH_WIDTH'(len_pick);
            send_bar(bar);
        end
        bar_if.valid <= 1'b0;
        calm = 1'b0;

        // Drain every awaited word, then watch for strays
        while (model.awaited_means.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (model.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> variable_window_moving_average_unit.f
+incdir+src
src/vwma_pkg.sv
src/vwma_if.sv
src/vwma_ring_ram.sv
src/vwma_divider.sv
src/variable_window_moving_average_unit.sv
tb/sv/variable_window_moving_average_unit_tb.sv
